[rtl/core/dtr_pkg.sv]
// Package for the dead band threshold reporter: codes, widths and the report type.
`default_nettype none

package dtr_pkg;

   // Default channel count
   localparam int DTR_CHANNELS = 4;

   // Field widths
   localparam int CHAN_W  = 2;
   localparam int TEMP_W  = 12;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // Report kinds
   localparam logic [KIND_W-1:0] KIND_TEMP      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_THRESHOLD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ENABLE    = 2'd2;

   // Request commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_ENABLE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_BAND      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STATE_INVERSE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SILENT         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FORCE_PUBLISH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_ENABLE = 3'd5;

   // Register reset values
   localparam logic [TEMP_W-1:0] DEAD_BAND_RESET = 12'd2;

   // Threshold state codes
   localparam logic [1:0] TSTATE_UNKNOWN = 2'd2;

   // One report as held in the result buffer
   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [CHAN_W-1:0]        channel;
      logic signed [TEMP_W-1:0] value;
      logic                     last;
   } report_type;

endpackage

`default_nettype wire

[rtl/core/deadband_threshold_reporter.sv]
// Top level of the per-channel report-by-exception filter with threshold reporting.
//
//   channel  direction  contents
//   req_*    in         command (tuser), channel / temperature / enable value (tdata)
//   rsp_*    out        report kind (tuser), channel / value (tdata), last (tlast)
//   csr_*    in         register index and write data, always ready
//
// A request is registered on acceptance, evaluated against the channel state in the
// next cycle and its reports, none, one or two, loaded into a two-entry result buffer.
// The single result port sets the pace: a request that yields two reports holds back the
// next request until the second is taken. Results pass through the input register and
// the result buffer. A stalled result port back-pressures the input register only.
// Reset is synchronous; all state but last_sent and the payload registers returns to defaults at once.
`default_nettype none

module deadband_threshold_reporter
   import dtr_pkg::*;
#(
   parameter int CHANNELS = DTR_CHANNELS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,  // channel[1:0], temperature[13:2],
                                                  // enable_value[14], zero[15]
   input  wire logic                  req_tuser,  // command
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,  // report_channel[1:0],
                                                  // report_value[13:2], zero[15:14]
   output logic [KIND_W-1:0]          rsp_tuser,  // report_kind
   output logic                       rsp_tlast,  // last
   // register write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EXT_W = (CH_W > CHAN_W) ? CH_W : CHAN_W;

   // Configuration registers
   logic [TEMP_W-1:0]        dead_band_ff, dead_band_in;
   logic signed [TEMP_W-1:0] threshold_ff, threshold_in;
   logic                     state_inverse_ff, state_inverse_in;
   logic                     silent_ff, silent_in;
   logic                     force_publish_ff, force_publish_in;
   logic                     default_enable_ff, default_enable_in;
   logic                     enabled_ff, enabled_in;

   // Channel state
   logic signed [TEMP_W-1:0] last_sent_ff [CHANNELS];
   logic signed [TEMP_W-1:0] last_sent_in [CHANNELS];
   logic                     primed_ff [CHANNELS];
   logic                     primed_in [CHANNELS];
   logic [1:0]               tstate_ff [CHANNELS];
   logic [1:0]               tstate_in [CHANNELS];

   // Input register
   logic                     in_vld_ff, in_vld_in;
   logic                     in_cmd_ff, in_cmd_in;
   logic [CHAN_W-1:0]        in_chan_ff, in_chan_in;
   logic signed [TEMP_W-1:0] in_temp_ff, in_temp_in;
   logic                     in_want_ff, in_want_in;

   // Result buffer
   logic [1:0]  out_cnt_ff, out_cnt_in;
   report_type  out0_ff, out0_in;
   report_type  out1_ff, out1_in;

   logic req_take, pop, can_load, fire, csr_wr;

   // Evaluation signals
   logic [EXT_W-1:0]         ch_ext;
   logic [CH_W-1:0]          ch_idx;
   logic                     in_range;
   logic signed [TEMP_W-1:0] last_val;
   logic signed [TEMP_W:0]   diff;
   logic [TEMP_W:0]          abs_diff;
   logic                     changed;
   logic                     temp_emit, thr_emit;
   logic                     above, st;
   report_type               temp_rep, thr_rep, en_rep, r0, r1;
   logic [1:0]               n_res;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid & csr_ready;
   assign rsp_tvalid = (out_cnt_ff != 2'd0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign can_load   = (out_cnt_ff == 2'd0) | ((out_cnt_ff == 2'd1) & pop);
   assign fire       = in_vld_ff & can_load;
   assign req_tready = ~in_vld_ff | fire;
   assign req_take   = req_tvalid & req_tready;

   // Result port
   assign rsp_tuser = out0_ff.kind;
   assign rsp_tlast = out0_ff.last;
   assign rsp_tdata = {2'b00, out0_ff.value, out0_ff.channel};

   // Channel lookup
   assign ch_ext   = EXT_W'(in_chan_ff);
   assign ch_idx   = ch_ext[CH_W-1:0];
   assign in_range = (32'(in_chan_ff) < CHANNELS);
   assign last_val = last_sent_ff[ch_idx];

   // Dead band test
   assign diff     = {in_temp_ff[TEMP_W-1], in_temp_ff} - {last_val[TEMP_W-1], last_val};
   assign abs_diff = diff[TEMP_W] ? (TEMP_W+1)'(-diff) : diff;
   assign changed  = ~primed_ff[ch_idx] | (abs_diff >= {1'b0, dead_band_ff});

   // Threshold test
   assign above = (in_temp_ff > threshold_ff);
   assign st    = above ? ~state_inverse_ff : state_inverse_ff;

   // Evaluate the request held in the input register
   always_comb begin
      temp_emit = 1'b0;
      thr_emit  = 1'b0;
      if (in_cmd_ff == CMD_SAMPLE && enabled_ff && in_range) begin
         temp_emit = ~silent_ff & (changed | force_publish_ff);
         thr_emit  = (threshold_ff != '0) & ({1'b0, st} != tstate_ff[ch_idx]);
      end

      temp_rep = '{kind: KIND_TEMP, channel: in_chan_ff, value: in_temp_ff, last: ~thr_emit};
      thr_rep  = '{kind: KIND_THRESHOLD, channel: in_chan_ff,
                   value: TEMP_W'(st), last: 1'b1};
      en_rep   = '{kind: KIND_ENABLE, channel: '0, value: TEMP_W'(in_want_ff), last: 1'b1};

      if (in_cmd_ff == CMD_ENABLE) begin
         r0    = en_rep;
         r1    = en_rep;
         n_res = (in_want_ff != enabled_ff) ? 2'd1 : 2'd0;
      end else begin
         r0    = temp_emit ? temp_rep : thr_rep;
         r1    = thr_rep;
         n_res = 2'(temp_emit) + 2'(thr_emit);
      end
   end

   // Next state
   always_comb begin
      dead_band_in      = dead_band_ff;
      threshold_in      = threshold_ff;
      state_inverse_in  = state_inverse_ff;
      silent_in         = silent_ff;
      force_publish_in  = force_publish_ff;
      default_enable_in = default_enable_ff;
      enabled_in        = enabled_ff;
      last_sent_in      = last_sent_ff;
      primed_in         = primed_ff;
      tstate_in         = tstate_ff;

      // register writes
      if (csr_wr) begin
         case (csr_index)
            REG_DEAD_BAND:      dead_band_in = csr_data;
            REG_THRESHOLD:      threshold_in = csr_data;
            REG_STATE_INVERSE:  state_inverse_in = csr_data[0];
            REG_SILENT:         silent_in = csr_data[0];
            REG_FORCE_PUBLISH:  force_publish_in = csr_data[0];
            REG_DEFAULT_ENABLE: begin
               default_enable_in = csr_data[0];
               enabled_in        = csr_data[0];
            end
            default: ;
         endcase
      end

      // state updates from the evaluated request
      if (fire) begin
         if (in_cmd_ff == CMD_ENABLE) begin
            enabled_in = in_want_ff;
         end
         if (temp_emit) begin
            last_sent_in[ch_idx] = in_temp_ff;
            primed_in[ch_idx]    = 1'b1;
         end
         if (thr_emit) begin
            tstate_in[ch_idx] = {1'b0, st};
         end
      end

      // input register
      in_vld_in  = in_vld_ff;
      in_cmd_in  = in_cmd_ff;
      in_chan_in = in_chan_ff;
      in_temp_in = in_temp_ff;
      in_want_in = in_want_ff;
      if (req_take) begin
         in_vld_in  = 1'b1;
         in_cmd_in  = req_tuser;
         in_chan_in = req_tdata[1:0];
         in_temp_in = req_tdata[13:2];
         in_want_in = req_tdata[14];
      end else if (fire) begin
         in_vld_in = 1'b0;
      end

      // result buffer: load a fresh pair or shift after a pop
      out_cnt_in = out_cnt_ff;
      out0_in    = out0_ff;
      out1_in    = out1_ff;
      if (fire) begin
         out_cnt_in = n_res;
         out0_in    = r0;
         out1_in    = r1;
      end else if (pop) begin
         out_cnt_in = out_cnt_ff - 2'd1;
         out0_in    = out1_ff;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_band_ff      <= DEAD_BAND_RESET;
         threshold_ff      <= '0;
         state_inverse_ff  <= 1'b0;
         silent_ff         <= 1'b0;
         force_publish_ff  <= 1'b0;
         default_enable_ff <= 1'b1;
         enabled_ff        <= 1'b1;
         in_vld_ff         <= 1'b0;
         out_cnt_ff        <= 2'd0;
         for (int i = 0; i < CHANNELS; i++) begin
            primed_ff[i] <= 1'b0;
            tstate_ff[i] <= TSTATE_UNKNOWN;
         end
      end else begin
         dead_band_ff      <= dead_band_in;
         threshold_ff      <= threshold_in;
         state_inverse_ff  <= state_inverse_in;
         silent_ff         <= silent_in;
         force_publish_ff  <= force_publish_in;
         default_enable_ff <= default_enable_in;
         enabled_ff        <= enabled_in;
         in_vld_ff         <= in_vld_in;
         out_cnt_ff        <= out_cnt_in;
         primed_ff         <= primed_in;
         tstate_ff         <= tstate_in;
      end
   end

   // Payload registers; last_sent only affects the result once primed is set
   always_ff @(posedge clock) begin
      last_sent_ff <= last_sent_in;
      in_cmd_ff    <= in_cmd_in;
      in_chan_ff   <= in_chan_in;
      in_temp_ff   <= in_temp_in;
      in_want_ff   <= in_want_in;
      out0_ff      <= out0_in;
      out1_ff      <= out1_in;
   end

`ifndef NO_ASSERTIONS
   // a full buffer holds a non-final report followed by the final one
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (out_cnt_ff == 2'd2) |-> (!out0_ff.last && out1_ff.last))
      else $error("result pair out of order");

   // a single buffered report always closes its request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (out_cnt_ff == 2'd1) |-> out0_ff.last)
      else $error("lone result not marked last");

   // the buffer never holds more than two reports
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("result buffer overfilled");

   // an enable report stands alone and names channel zero
   a_enable_rep: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out0_ff.kind == KIND_ENABLE) |-> (out0_ff.last && out0_ff.channel == '0))
      else $error("malformed enable report");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking bench for the dead band threshold reporter: predicted reports against the result stream.
`default_nettype none

module tb;
   import dtr_pkg::*;

   // Spare register indexes that the block must ignore
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 180;
   localparam int DRAIN_SLACK  = 8;
   localparam int LONG_STALL   = 400;

   typedef struct packed {
      logic                     cmd;
      logic [CHAN_W-1:0]        ch;
      logic signed [TEMP_W-1:0] temp;
      logic                     en;
   } sensor_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   deadband_threshold_reporter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Stimulus and expectation stores
   sensor_request_type pending_requests [$];
   report_type         expected_reports [$];
   int                 mismatches = 0;

   // Idling control, set per phase
   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   logic long_stall_go = 1'b0;
   int   stall_left = 0;

   // Shadow of the block: registers and channel state
   logic [TEMP_W-1:0]        cfg_dead_band;
   logic signed [TEMP_W-1:0] cfg_threshold;
   logic                     cfg_inverse;
   logic                     cfg_silent;
   logic                     cfg_force;
   logic                     cfg_default_en;
   logic signed [TEMP_W-1:0] sent_temp   [DTR_CHANNELS];
   logic                     chan_primed [DTR_CHANNELS];
   logic [1:0]               chan_tstate [DTR_CHANNELS];
   logic                     block_enabled;

   // Generator hints for steering samples near the interesting edges
   int                       gen_dead_band = 2;
   logic signed [TEMP_W-1:0] gen_threshold = '0;
   logic signed [TEMP_W-1:0] gen_centre [DTR_CHANNELS] = '{default: '0};

   initial begin
      forever #4 clock = ~clock;
   end

   // Work out the reports that one accepted request gives rise to
   task automatic predict_reports(input logic cmd, input logic [CHAN_W-1:0] ch,
                                  input logic signed [TEMP_W-1:0] t, input logic en);
      report_type rep [2];
      int         n;
      int         diff;
      logic [1:0] st;
      n = 0;
      if (cmd == CMD_ENABLE) begin
         if (en != block_enabled) begin
            block_enabled = en;
            rep[0].kind    = KIND_ENABLE;
            rep[0].channel = '0;
            rep[0].value   = {11'd0, en};
            n = 1;
         end
      end else if (block_enabled && int'(ch) < DTR_CHANNELS) begin
         if (!cfg_silent) begin
            diff = int'(t) - int'(sent_temp[ch]);
            if (diff < 0) diff = -diff;
            if (!chan_primed[ch] || diff >= int'(cfg_dead_band) || cfg_force) begin
               sent_temp[ch]   = t;
               chan_primed[ch] = 1'b1;
               rep[n].kind     = KIND_TEMP;
               rep[n].channel  = ch;
               rep[n].value    = t;
               n++;
            end
         end
         if (cfg_threshold != 0) begin
            st = (t > cfg_threshold) ? {1'b0, ~cfg_inverse} : {1'b0, cfg_inverse};
            if (st != chan_tstate[ch]) begin
               chan_tstate[ch] = st;
               rep[n].kind     = KIND_THRESHOLD;
               rep[n].channel  = ch;
               rep[n].value    = {10'd0, st};
               n++;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         rep[i].last = (i == n - 1);
         expected_reports.push_back(rep[i]);
      end
   endtask

   // Request driver: next pending request offered once the current one is taken
   always @(posedge clock) begin : drive_requests
      sensor_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            nxt = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, nxt.en, nxt.temp, nxt.ch};
            req_tuser  <= nxt.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result ready: random stalls plus one long hold-off on demand
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (long_stall_go) begin
         rsp_tready <= 1'b0;
         stall_left <= LONG_STALL;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Shadow update on register writes and requests, check on results
   always @(posedge clock) begin : track_reports
      report_type want;
      if (reset) begin
         cfg_dead_band  = DEAD_BAND_RESET;
         cfg_threshold  = '0;
         cfg_inverse    = 1'b0;
         cfg_silent     = 1'b0;
         cfg_force      = 1'b0;
         cfg_default_en = 1'b1;
         block_enabled  = 1'b1;
         for (int i = 0; i < DTR_CHANNELS; i++) begin
            sent_temp[i]   = '0;
            chan_primed[i] = 1'b0;
            chan_tstate[i] = TSTATE_UNKNOWN;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DEAD_BAND:      cfg_dead_band = csr_data;
               REG_THRESHOLD:      cfg_threshold = csr_data;
               REG_STATE_INVERSE:  cfg_inverse   = csr_data[0];
               REG_SILENT:         cfg_silent    = csr_data[0];
               REG_FORCE_PUBLISH:  cfg_force     = csr_data[0];
               REG_DEFAULT_ENABLE: begin
                  cfg_default_en = csr_data[0];
                  block_enabled  = csr_data[0];
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_reports(req_tuser, req_tdata[1:0], req_tdata[13:2], req_tdata[14]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected report: kind %0d chan %0d value %0d last %0d",
                           rsp_tuser, rsp_tdata[1:0], $signed(rsp_tdata[13:2]), rsp_tlast);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_tuser != want.kind || rsp_tdata[1:0] != want.channel ||
                   rsp_tdata[13:2] != want.value || rsp_tlast != want.last ||
                   rsp_tdata[15:14] != 2'b00) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("report mismatch: expected kind %0d chan %0d value %0d last %0d,",
                            want.kind, want.channel, want.value, want.last);
                     $display(" got kind %0d chan %0d value %0d last %0d pad %0d",
                              rsp_tuser, rsp_tdata[1:0], $signed(rsp_tdata[13:2]),
                              rsp_tlast, rsp_tdata[15:14]);
                  end
               end
            end
         end
      end
   end

   task automatic push_request(input logic cmd, input int ch, input int temp, input logic en);
      sensor_request_type r;
      r.cmd  = cmd;
      r.ch   = ch[CHAN_W-1:0];
      r.temp = temp[TEMP_W-1:0];
      r.en   = en;
      pending_requests.push_back(r);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Idle point: nothing left to send, nothing outstanding, pipeline flushed;
   // looked at mid-cycle so the driver and the shadow have settled
   task automatic wait_for_drain();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_reports.size() != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // One-bit registers get junk in the upper data bits
   function automatic logic [CSR_DATA_W-1:0] flag_word(input logic b);
      logic [31:0] junk;
      junk = $urandom();
      return {junk[10:0], b};
   endfunction

   task automatic apply_settings(input int db, input int thr, input logic inv,
                                 input logic sil, input logic frc, input logic den);
      write_reg(REG_DEAD_BAND, db[11:0]);
      write_reg(REG_THRESHOLD, thr[11:0]);
      write_reg(REG_STATE_INVERSE, flag_word(inv));
      write_reg(REG_SILENT, flag_word(sil));
      write_reg(REG_FORCE_PUBLISH, flag_word(frc));
      write_reg(REG_DEFAULT_ENABLE, flag_word(den));
      gen_dead_band = db;
      gen_threshold = thr[11:0];
   endtask

   task automatic set_idling(input int mode);
      @(posedge clock);
      case (mode % 4)
         0: begin tx_idle_pct <= 0;  rx_idle_pct <= 0;  end
         1: begin tx_idle_pct <= 78; rx_idle_pct <= 0;  end
         2: begin tx_idle_pct <= 0;  rx_idle_pct <= 78; end
         default: begin tx_idle_pct <= 16; rx_idle_pct <= 16; end
      endcase
   endtask

   // Random requests, mostly samples steered towards the dead band and threshold edges
   task automatic queue_random_items(input int count);
      int          r;
      int          ch;
      int          v;
      int          span;
      int          delta;
      logic [31:0] raw;
      for (int k = 0; k < count; k++) begin
         r   = $urandom_range(99);
         ch  = $urandom_range(DTR_CHANNELS - 1);
         raw = $urandom();
         if (r < 8) begin
            push_request(CMD_ENABLE, ch, int'(raw[11:0]), ($urandom_range(3) != 0));
         end else begin
            if (r < 35) begin
               span = (gen_dead_band > 40) ? 40 : gen_dead_band + 3;
               v = int'(gen_centre[ch]) + int'($urandom_range(2 * span)) - span;
            end else if (r < 50) begin
               delta = gen_dead_band + int'($urandom_range(2)) - 1;
               v = raw[12] ? int'(gen_centre[ch]) + delta : int'(gen_centre[ch]) - delta;
            end else if (r < 75) begin
               v = int'(gen_threshold) + int'($urandom_range(4)) - 2;
            end else begin
               v = int'($signed(raw[11:0]));
            end
            if (v > 2047) v = 2047;
            if (v < -2048) v = -2048;
            gen_centre[ch] = v[11:0];
            push_request(CMD_SAMPLE, ch, v, raw[13]);
         end
      end
   endtask

   // Main sequence
   initial begin : run_sequence
      int          db;
      int          thr;
      logic [31:0] raw;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait_for_drain();

      // Directed: reset settings, first report, dead band edge, range extremes, enable
      push_request(CMD_SAMPLE, 0, 0, 0);
      push_request(CMD_SAMPLE, 0, 1, 0);
      push_request(CMD_SAMPLE, 0, 2, 1);
      push_request(CMD_SAMPLE, 1, 2047, 0);
      push_request(CMD_SAMPLE, 2, -2048, 1);
      push_request(CMD_SAMPLE, 3, -1, 0);
      push_request(CMD_ENABLE, 0, 0, 1);
      push_request(CMD_ENABLE, 2, 123, 0);
      push_request(CMD_SAMPLE, 1, 5, 1);
      push_request(CMD_ENABLE, 3, -1, 1);
      push_request(CMD_SAMPLE, 1, -2048, 0);
      wait_for_drain();
      // threshold from unknown, then crossing it
      write_reg(REG_THRESHOLD, 12'd100);
      push_request(CMD_SAMPLE, 0, 100, 0);
      push_request(CMD_SAMPLE, 0, 101, 0);
      push_request(CMD_SAMPLE, 1, 2047, 0);
      wait_for_drain();
      // silent with inverted state
      write_reg(REG_STATE_INVERSE, flag_word(1'b1));
      write_reg(REG_SILENT, flag_word(1'b1));
      push_request(CMD_SAMPLE, 0, -2048, 0);
      push_request(CMD_SAMPLE, 0, 101, 1);
      wait_for_drain();
      // forced publishing of a repeated value, threshold off
      write_reg(REG_SILENT, flag_word(1'b0));
      write_reg(REG_FORCE_PUBLISH, flag_word(1'b1));
      write_reg(REG_THRESHOLD, 12'd0);
      push_request(CMD_SAMPLE, 3, -1, 0);
      push_request(CMD_SAMPLE, 3, -1, 0);
      push_request(CMD_SAMPLE, 0, 2047, 0);
      wait_for_drain();
      // disabled through the default enable register
      write_reg(REG_DEFAULT_ENABLE, flag_word(1'b0));
      push_request(CMD_SAMPLE, 2, 7, 0);
      push_request(CMD_ENABLE, 0, 0, 0);
      wait_for_drain();

      // Random phases over settings and idling modes
      for (int p = 0; p < PHASES; p++) begin
         set_idling(p);
         raw = $urandom();
         case (p)
            0: apply_settings(0, 2047, 1'b0, 1'b0, 1'b0, 1'b1);
            1: apply_settings(4095, -2048, 1'b1, 1'b0, 1'b0, 1'b1);
            2: begin
               apply_settings(1, -1, 1'b0, 1'b1, 1'b0, 1'b1);
               write_reg(REG_SPARE_LO, raw[11:0]);
               write_reg(REG_SPARE_HI, raw[23:12]);
            end
            3: apply_settings(3, 1, 1'b1, 1'b0, 1'b1, 1'b0);
            default: begin
               case ($urandom_range(3))
                  0: db = $urandom_range(2);
                  1: db = $urandom_range(15);
                  2: db = $urandom_range(4095);
                  default: db = 4095;
               endcase
               case ($urandom_range(3))
                  0: thr = 0;
                  1: thr = int'($signed(raw[11:0]));
                  2: thr = int'($urandom_range(40)) - 20;
                  default: thr = raw[12] ? 2047 : -2048;
               endcase
               apply_settings(db, thr, raw[13], ($urandom_range(3) == 0),
                              ($urandom_range(3) == 0), ($urandom_range(7) != 0));
            end
         endcase
         queue_random_items(PHASE_ITEMS / 2);
         // sender pauses until everything outstanding has come back
         wait_for_drain();
         queue_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
         wait_for_drain();
      end

      // Back-pressure: receiver holds off while the sender keeps offering
      set_idling(0);
      apply_settings(2, 50, 1'b0, 1'b0, 1'b1, 1'b1);
      @(posedge clock);
      long_stall_go <= 1'b1;
      @(posedge clock);
      long_stall_go <= 1'b0;
      queue_random_items(80);
      wait_for_drain();

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("deadband_threshold_reporter: match");
      end else begin
         $display("deadband_threshold_reporter: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(2_000_000);
      $display("deadband_threshold_reporter: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
